@@ rtl/alt_pkg.sv @@
// Shared types and character codes for the array language tokenizer.
package alt_pkg;

	localparam int unsigned MAX_SOURCE = 65536;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	typedef enum logic [2:0] {
		KIND_IDENT,
		KIND_INT,
		KIND_FLOAT,
		KIND_STRING,
		KIND_PUNCT,
		KIND_END,
		KIND_UNKNOWN
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  sym;
		logic [15:0] start;
		logic [15:0] len;
		logic        unterm;
		logic        last;
	} token_t;

	// Up to two tokens per source byte, in emission order.
	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} step_t;

	typedef struct packed {
		logic [2:0] level;
		logic       room2;
	} qstat_t;

endpackage

@@ rtl/alt_in_if.sv @@
// Source byte channel.
interface alt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;

	modport source(output valid, source_byte, input ready);
	modport sink(input valid, source_byte, output ready);
endinterface

@@ rtl/alt_out_if.sv @@
// Token channel.
interface alt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [7:0]  symbol_char;
	logic [15:0] start_pos;
	logic [15:0] token_len;
	logic        unterminated;
	logic        last_of_run;

	modport source(output valid, token_kind, symbol_char, start_pos, token_len,
		unterminated, last_of_run, input ready);
	modport sink(input valid, token_kind, symbol_char, start_pos, token_len,
		unterminated, last_of_run, output ready);
endinterface

@@ rtl/array_language_tokenizer_unit.sv @@
// Top level of the array language tokenizer.
//
//  channel | dir | payload                                         | transfer
//  src     | in  | source_byte                                     | valid & ready
//  tok     | out | token_kind symbol_char start_pos token_len      | valid & ready
//          |     | unterminated last_of_run                        |
//
// One source byte per cycle while src.ready is high; the lexer state advances in the
// cycle the byte transfers. A byte makes zero, one or two tokens, which go into a
// four-entry token queue whose single output port sets the token rate at one per cycle
// while tok.ready is high. src.ready drops while the queue holds three or more tokens.
// Reset returns the lexer to the start of a source and empties the queue.
module array_language_tokenizer_unit #(
	parameter int unsigned MAX_SOURCE = alt_pkg::MAX_SOURCE
) (
	input logic        clk,
	input logic        arst_n,
	alt_in_if.sink     src,
	alt_out_if.source  tok
);

	alt_pkg::step_t  step;
	alt_pkg::token_t head;
	alt_pkg::qstat_t stat;
	logic            fire, pop;

	assign fire      = src.valid & src.ready;
	assign pop       = tok.valid & tok.ready;
	assign src.ready = stat.room2;

	alt_core #(.MAX_SOURCE(MAX_SOURCE)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.src_byte (src.source_byte),
		.step     (step)
	);

	alt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.step   (step),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	assign tok.valid        = (stat.level != 3'd0);
	assign tok.token_kind   = head.kind;
	assign tok.symbol_char  = head.sym;
	assign tok.start_pos    = head.start;
	assign tok.token_len    = head.len;
	assign tok.unterminated = head.unterm;
	assign tok.last_of_run  = head.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (stat.level <= 3'd2))
		else $error("byte taken without room for two tokens");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= 3'd4)
		else $error("token queue level out of range");

	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && src.source_byte == alt_pkg::CH_NUL) |=> tok.valid)
		else $error("no token pending after end of source");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !fire) |=> (stat.level == $past(stat.level) - 3'd1))
		else $error("queue level did not drop on delivery");

endmodule

@@ rtl/alt_core.sv @@
// Lexer state and per-byte token decision.
module alt_core #(
	parameter int unsigned MAX_SOURCE = alt_pkg::MAX_SOURCE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        src_byte,
	output alt_pkg::step_t    step
);

	localparam int unsigned PW = $clog2(MAX_SOURCE);
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_SOURCE - 1);
	localparam logic [PW:0]   MS_EXT = (PW+1)'(MAX_SOURCE);

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_NUM, M_STRING, M_COMMENT, M_MINUS, M_DOT
	} mode_t;

	typedef enum logic [1:0] {C_NONE, C_NUMBER, C_RPAREN, C_OTHER} cls_t;

	mode_t          mode_q, mode_d;
	cls_t           cls_q, cls_d, cls_mid;
	logic [PW-1:0]  start_q, start_d;
	logic [PW-1:0]  pos_q;
	logic [7:0]     prev_q;
	logic           saw_q, saw_d;

	alt_pkg::token_t e0, e1;
	logic            e0_v, e1_v, handle, after_val;
	logic [PW-1:0]   span0;
	logic [15:0]     len0, len1, pos16;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		logic r;
		case (c) inside
			8'h2F, 8'h2A, 8'h2B, 8'h25, 8'h21, 8'h2D, 8'h2E, 8'h27, 8'h40, 8'h7E,
			8'h23, 8'h2C, 8'h28, 8'h29, 8'h5C, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3C,
			8'h3E, 8'h3B, 8'h3A, 8'h3F, 8'h7C, 8'h3D, 8'h26: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Low 16 bits of a position-sized value.
	function automatic logic [15:0] fld(logic [PW:0] v);
		logic [PW+16:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	function automatic cls_t class_of(alt_pkg::token_t t);
		cls_t r;
		if (t.kind == alt_pkg::KIND_INT || t.kind == alt_pkg::KIND_FLOAT) begin
			r = C_NUMBER;
		end else if (t.kind == alt_pkg::KIND_PUNCT && t.sym == alt_pkg::CH_RPAREN) begin
			r = C_RPAREN;
		end else begin
			r = C_OTHER;
		end
		return r;
	endfunction

	function automatic alt_pkg::token_t mk(alt_pkg::kind_t k, logic [7:0] s,
		logic [15:0] st, logic [15:0] ln, logic u);
		alt_pkg::token_t t;
		t.kind   = k;
		t.sym    = s;
		t.start  = st;
		t.len    = ln;
		t.unterm = u;
		t.last   = 1'b0;
		return t;
	endfunction

	// Token span modulo the source size.
	always_comb begin
		if (pos_q >= start_q) begin
			span0 = pos_q - start_q;
		end else begin
			span0 = PW'({1'b0, pos_q} + MS_EXT - {1'b0, start_q});
		end
		len0  = fld({1'b0, span0});
		len1  = fld({1'b0, span0} + (PW+1)'(1));
		pos16 = fld({1'b0, pos_q});
	end

	always_comb begin
		e0      = '0;
		e1      = '0;
		e0_v    = 1'b0;
		e1_v    = 1'b0;
		handle  = 1'b0;
		mode_d  = mode_q;
		start_d = start_q;
		saw_d   = saw_q;
		if (src_byte == alt_pkg::CH_NUL) begin
			// Flush the open token, then end.
			unique case (mode_q)
				M_IDENT: begin
					e0_v = 1'b1;
					e0   = mk(alt_pkg::KIND_IDENT, 8'h00, fld({1'b0, start_q}), len0, 1'b0);
				end
				M_NUM: begin
					e0_v = 1'b1;
					e0   = mk(saw_q ? alt_pkg::KIND_FLOAT : alt_pkg::KIND_INT, 8'h00,
						fld({1'b0, start_q}), len0, 1'b0);
				end
				M_STRING: begin
					e0_v = 1'b1;
					e0   = mk(alt_pkg::KIND_STRING, 8'h00, fld({1'b0, start_q}), len0, 1'b1);
				end
				M_MINUS: begin
					e0_v = 1'b1;
					e0   = mk(alt_pkg::KIND_PUNCT, alt_pkg::CH_MINUS, fld({1'b0, start_q}),
						16'd1, 1'b0);
				end
				M_DOT: begin
					e0_v = 1'b1;
					e0   = mk(alt_pkg::KIND_PUNCT, alt_pkg::CH_POINT, fld({1'b0, start_q}),
						16'd1, 1'b0);
				end
				default: ;
			endcase
			e1_v = 1'b1;
			e1   = mk(alt_pkg::KIND_END, 8'h00, pos16, 16'd1, 1'b0);
		end else begin
			unique case (mode_q)
				M_IDENT: begin
					if (!(is_alpha(src_byte) || is_digit(src_byte))) begin
						e0_v   = 1'b1;
						e0     = mk(alt_pkg::KIND_IDENT, 8'h00, fld({1'b0, start_q}), len0, 1'b0);
						mode_d = M_IDLE;
						handle = 1'b1;
					end
				end
				M_NUM: begin
					if (src_byte == alt_pkg::CH_POINT) begin
						saw_d = 1'b1;
					end else if (!is_digit(src_byte)) begin
						e0_v   = 1'b1;
						e0     = mk(saw_q ? alt_pkg::KIND_FLOAT : alt_pkg::KIND_INT, 8'h00,
							fld({1'b0, start_q}), len0, 1'b0);
						mode_d = M_IDLE;
						handle = 1'b1;
					end
				end
				M_STRING: begin
					if (src_byte == alt_pkg::CH_QUOTE) begin
						e0_v   = 1'b1;
						e0     = mk(alt_pkg::KIND_STRING, 8'h00, fld({1'b0, start_q}), len1, 1'b0);
						mode_d = M_IDLE;
					end
				end
				M_COMMENT: begin
					if (src_byte == alt_pkg::CH_NL) begin
						mode_d = M_IDLE;
					end
				end
				M_MINUS: begin
					if (is_digit(src_byte)) begin
						mode_d = M_NUM;
						saw_d  = 1'b0;
					end else begin
						e0_v   = 1'b1;
						e0     = mk(alt_pkg::KIND_PUNCT, alt_pkg::CH_MINUS, fld({1'b0, start_q}),
							16'd1, 1'b0);
						mode_d = M_IDLE;
						handle = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(src_byte)) begin
						mode_d = M_NUM;
						saw_d  = 1'b1;
					end else begin
						e0_v   = 1'b1;
						e0     = mk(alt_pkg::KIND_PUNCT, alt_pkg::CH_POINT, fld({1'b0, start_q}),
							16'd1, 1'b0);
						mode_d = M_IDLE;
						handle = 1'b1;
					end
				end
				default: begin
					mode_d = M_IDLE;
					handle = 1'b1;
				end
			endcase
		end

		// The closing token above already counts as the previous token here.
		cls_mid   = e0_v ? class_of(e0) : cls_q;
		after_val = (cls_mid == C_NUMBER) || (cls_mid == C_RPAREN);

		if (handle && src_byte != alt_pkg::CH_SPACE && src_byte != alt_pkg::CH_NL) begin
			if (is_digit(src_byte)) begin
				mode_d  = M_NUM;
				start_d = pos_q;
				saw_d   = 1'b0;
			end else if (is_alpha(src_byte)) begin
				mode_d  = M_IDENT;
				start_d = pos_q;
			end else if (src_byte == alt_pkg::CH_QUOTE) begin
				mode_d  = M_STRING;
				start_d = pos_q;
			end else if (src_byte == alt_pkg::CH_SLASH) begin
				if (cls_mid == C_NONE || prev_q == alt_pkg::CH_SPACE) begin
					mode_d = M_COMMENT;
				end else begin
					e1_v = 1'b1;
					e1   = mk(alt_pkg::KIND_PUNCT, src_byte, pos16, 16'd1, 1'b0);
				end
			end else if (src_byte == alt_pkg::CH_MINUS) begin
				if (after_val && prev_q != alt_pkg::CH_SPACE) begin
					e1_v = 1'b1;
					e1   = mk(alt_pkg::KIND_PUNCT, src_byte, pos16, 16'd1, 1'b0);
				end else begin
					mode_d  = M_MINUS;
					start_d = pos_q;
				end
			end else if (src_byte == alt_pkg::CH_POINT) begin
				mode_d  = M_DOT;
				start_d = pos_q;
			end else if (is_punct(src_byte)) begin
				e1_v = 1'b1;
				e1   = mk(alt_pkg::KIND_PUNCT, src_byte, pos16, 16'd1, 1'b0);
			end else begin
				e1_v = 1'b1;
				e1   = mk(alt_pkg::KIND_UNKNOWN, 8'h00, pos16, 16'd1, 1'b0);
			end
		end

		cls_d = e1_v ? class_of(e1) : cls_mid;

		// Pack emitted tokens to the front and flag the final one.
		step.v0      = e0_v | e1_v;
		step.v1      = e0_v & e1_v;
		step.t0      = e0_v ? e0 : e1;
		step.t0.last = !(e0_v & e1_v);
		step.t1      = e1;
		step.t1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			cls_q   <= C_NONE;
			start_q <= '0;
			pos_q   <= '0;
			prev_q  <= '0;
			saw_q   <= 1'b0;
		end else if (fire) begin
			if (src_byte == alt_pkg::CH_NUL) begin
				mode_q  <= M_IDLE;
				cls_q   <= C_NONE;
				start_q <= '0;
				pos_q   <= '0;
				prev_q  <= '0;
				saw_q   <= 1'b0;
			end else begin
				mode_q  <= mode_d;
				cls_q   <= cls_d;
				start_q <= start_d;
				pos_q   <= (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
				prev_q  <= src_byte;
				saw_q   <= saw_d;
			end
		end
	end

endmodule

@@ rtl/alt_queue.sv @@
// Four-entry token queue: takes up to two tokens a cycle, delivers one.
module alt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  alt_pkg::step_t   step,
	input  logic             pop,
	output alt_pkg::token_t  head,
	output alt_pkg::qstat_t  stat
);

	alt_pkg::token_t ent_q [4];
	logic [1:0]      rd_q, wr_q;
	logic [2:0]      level_q;
	logic            push0, push1;
	logic [2:0]      n_push;

	assign push0  = fire & step.v0;
	assign push1  = fire & step.v1;
	assign n_push = {2'b0, push0} + {2'b0, push1};

	always_ff @(posedge clk) begin
		if (push0) begin
			ent_q[wr_q] <= step.t0;
		end
		if (push1) begin
			ent_q[wr_q + 2'd1] <= step.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[1:0];
			rd_q    <= rd_q + {1'b0, pop};
			level_q <= level_q + n_push - {2'b0, pop};
		end
	end

	assign head       = ent_q[rd_q];
	assign stat.level = level_q;
	assign stat.room2 = (level_q <= 3'd2);

endmodule
